// ----- src/srm_pkg.sv -----
// Shared types and constants for the segment run merger.
// Used by srm_front, srm_back and segment_run_merger; depends on nothing.
package srm_pkg;

  localparam int TIME_WIDTH  = 48;
  localparam int LEVEL_WIDTH = 32;

  // Stream data width: start, length and level packed, rounded up to whole bytes.
  localparam int DATA_WIDTH  = ((2 * TIME_WIDTH + LEVEL_WIDTH + 7) / 8) * 8;

  // Command queue between the front and the back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;

  // One classified input segment on its way to the back.
  typedef struct packed {
    logic [TIME_WIDTH-1:0]         start;
    logic [TIME_WIDTH-1:0]         length;
    logic signed [LEVEL_WIDTH-1:0] level;
    logic                          len_zero;
    logic                          final_seg;
  } cmd_t;

  // One result item.
  typedef struct packed {
    logic [TIME_WIDTH-1:0]         start;
    logic [TIME_WIDTH-1:0]         length;
    logic signed [LEVEL_WIDTH-1:0] level;
    logic                          final_out;
    logic                          empty_marker;
  } res_t;

endpackage

// ----- src/segment_run_merger.sv -----
// Top level of the segment run merger: front, command queue and back joined.
// Depends on srm_pkg, srm_front and srm_back.
//
// Usage: segments (start, length, level) arrive as requests on the s_ side;
// s_tlast marks the last segment of a signal. Neighbouring segments of equal
// level, and zero-length segments, are merged into runs, and each closed run
// leaves as a request on the m_ side. m_tlast marks the last result of a
// signal and m_tuser marks an empty end marker that carries no run.
// A segment passes through the command queue and then the result register
// before its result can appear on the m_ side.
// Throughput: one segment per cycle while the back is not stalled. A segment
// that both closes a run and is final yields two results, and the back takes
// no command while the second waits in the spare; the four-entry command queue
// absorbs this, so the rate is set by the single merge unit in the back, one command per cycle.
// Reset (rst, synchronous) empties the queue, drops any open run and clears
// the result register. When the receiver holds m_tready low, the back stops
// taking commands once the result register is full, and s_tready falls once
// the queue is full; nothing is lost.
module segment_run_merger import srm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // seg_start, seg_length, seg_level (lowest bit first), zero padded
  input  logic [DATA_WIDTH-1:0] s_tdata,
  // final_in
  input  logic                  s_tlast,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // run_start, run_length, run_level (lowest bit first), zero padded
  output logic [DATA_WIDTH-1:0] m_tdata,
  // final_out
  output logic                  m_tlast,
  // empty_marker
  output logic                  m_tuser
);

  logic q_valid;
  cmd_t q_head;
  logic q_pop;
  res_t res;

  // The front classifies each segment and queues it as a command.
  srm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .seg_valid  (s_tvalid),
    .seg_ready  (s_tready),
    .seg_start  (s_tdata[TIME_WIDTH-1:0]),
    .seg_length (s_tdata[2*TIME_WIDTH-1:TIME_WIDTH]),
    .seg_level  (s_tdata[2*TIME_WIDTH+LEVEL_WIDTH-1:2*TIME_WIDTH]),
    .final_in   (s_tlast),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .q_pop      (q_pop)
  );

  // The back holds the open run and issues the results.
  srm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .res_valid (m_tvalid),
    .res_ready (m_tready),
    .res       (res)
  );

  // Pack the run fields with the start in the lowest bits; padding is zero.
  assign m_tdata = DATA_WIDTH'({res.level, res.length, res.start});
  assign m_tlast = res.final_out;
  assign m_tuser = res.empty_marker;

endmodule

// ----- src/srm_front.sv -----
// Front of the segment run merger: accepts segment requests, classifies them
// and holds them in a short command queue. Depends on srm_pkg.
module srm_front import srm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  seg_valid,
  output logic                  seg_ready,
  input  logic [TIME_WIDTH-1:0] seg_start,
  input  logic [TIME_WIDTH-1:0] seg_length,
  input  logic [LEVEL_WIDTH-1:0] seg_level,
  input  logic                  final_in,
  output logic                  q_valid,
  output cmd_t                  q_head,
  input  logic                  q_pop
);

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  logic              pop;
  cmd_t              cmd_in;

  assign seg_ready = (count != QCNT_W'(QUEUE_DEPTH));
  assign push      = seg_valid && seg_ready;
  assign q_valid   = (count != '0);
  assign pop       = q_pop && q_valid;
  assign q_head    = entries[rd_ptr];

  // The only classification needed ahead of the run state is a zero length.
  always_comb begin
    cmd_in.start     = seg_start;
    cmd_in.length    = seg_length;
    cmd_in.level     = seg_level;
    cmd_in.len_zero  = (seg_length == '0);
    cmd_in.final_seg = final_in;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QUEUE_DEPTH))
    else $error("command queue count beyond depth");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + QCNT_W'(1))
    else $error("command queue count missed a push");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (rst)
    count == '0 |-> wr_ptr == rd_ptr)
    else $error("empty command queue with unequal pointers");
`endif

endmodule

// ----- src/srm_back.sv -----
// Back of the segment run merger: holds the open run, merges or closes it per
// command and drives the result register with a one-entry spare. Depends on srm_pkg.
module srm_back import srm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  input  cmd_t q_head,
  output logic q_pop,
  output logic res_valid,
  input  logic res_ready,
  output res_t res
);

  logic                          run_active;
  logic [TIME_WIDTH-1:0]         held_start;
  logic [TIME_WIDTH-1:0]         held_length;
  logic signed [LEVEL_WIDTH-1:0] held_level;

  logic out_valid;
  res_t out_res;
  logic pend_valid;
  res_t pend_res;

  logic                          can_pop;
  logic                          emit_close;
  logic [TIME_WIDTH:0]           sum;
  logic [TIME_WIDTH-1:0]         sat_length;
  logic                          new_active;
  logic [TIME_WIDTH-1:0]         new_start;
  logic [TIME_WIDTH-1:0]         new_length;
  logic signed [LEVEL_WIDTH-1:0] new_level;
  res_t                          close_res;
  res_t                          final_res;
  logic                          has_first;

  assign can_pop   = !pend_valid && (!out_valid || res_ready);
  assign q_pop     = q_valid && can_pop;
  assign res_valid = out_valid;
  assign res       = out_res;

  always_comb begin
    emit_close = run_active && !((q_head.level == held_level) || q_head.len_zero);
    sum        = {1'b0, held_length} + {1'b0, q_head.length};
    sat_length = sum[TIME_WIDTH] ? '1 : sum[TIME_WIDTH-1:0];
    new_active = run_active || !q_head.len_zero;
    if (run_active && !emit_close) begin
      new_start  = held_start;
      new_length = sat_length;
      new_level  = held_level;
    end else begin
      new_start  = q_head.start;
      new_length = q_head.length;
      new_level  = q_head.level;
    end

    close_res.start        = held_start;
    close_res.length       = held_length;
    close_res.level        = held_level;
    close_res.final_out    = 1'b0;
    close_res.empty_marker = 1'b0;

    if (new_active) begin
      final_res.start        = new_start;
      final_res.length       = new_length;
      final_res.level        = new_level;
      final_res.empty_marker = 1'b0;
    end else begin
      final_res.start        = '0;
      final_res.length       = '0;
      final_res.level        = '0;
      final_res.empty_marker = 1'b1;
    end
    final_res.final_out = 1'b1;

    has_first = emit_close || q_head.final_seg;
  end

  // Run state.
  always_ff @(posedge clk) begin
    if (rst) begin
      run_active <= 1'b0;
    end else if (q_pop) begin
      run_active <= new_active && !q_head.final_seg;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      held_start  <= new_start;
      held_length <= new_length;
      held_level  <= new_level;
    end
  end

  // Result register and spare entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      priority if (q_pop && has_first) begin
        out_valid  <= 1'b1;
        pend_valid <= emit_close && q_head.final_seg;
      end else if (pend_valid && (!out_valid || res_ready)) begin
        out_valid  <= 1'b1;
        pend_valid <= 1'b0;
      end else if (res_ready) begin
        out_valid  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    priority if (q_pop && has_first) begin
      out_res  <= emit_close ? close_res : final_res;
      pend_res <= final_res;
    end else if (pend_valid && (!out_valid || res_ready)) begin
      out_res  <= pend_res;
    end
  end

`ifndef SYNTHESIS
  a_pend_behind_out: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> out_valid)
    else $error("spare result held with no result in front of it");

  a_final_clears: assert property (@(posedge clk) disable iff (rst)
    q_pop && q_head.final_seg |=> !run_active)
    else $error("run left open after the final segment");

  a_empty_is_final: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.empty_marker |-> out_res.final_out)
    else $error("empty marker without final flag");
`endif

endmodule
